// File: hw/rtl/mvt_pkg.sv
// Shared types, op codes, word constants and the multiply helper for the matrix-vector transform unit.
// No dependencies; every other file in hw/rtl imports this package.

package mvt_pkg;

    localparam int WORD_W  = 32;
    localparam int PROD_W  = 2 * WORD_W;
    localparam int NFIELDS = 4;

    localparam logic [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_IDENT = 2'd1,
        OP_CLEAR = 2'd2,
        OP_XFORM = 2'd3
    } op_t;

    // The request fields, apart from the vector, sums and products, that travel down the cell chain.
    typedef struct packed {
        op_t                op;
        logic [1:0]         row;
        logic [1:0]         col;
        logic [WORD_W-1:0]  value;
    } cmd_t;

    function automatic logic signed [PROD_W-1:0] mul_q(
        input logic signed [WORD_W-1:0] a,
        input logic signed [WORD_W-1:0] b
    );
        mul_q = a * b;
    endfunction

endpackage

// File: hw/rtl/mvt_cell.sv
// One cell of the transform chain: holds one matrix column and multiplies it by one
// vector component. Depends on mvt_pkg.

module mvt_cell
    import mvt_pkg::*;
#(
    parameter int DIM       = 4,
    parameter int FRAC_BITS = 16,
    parameter int K         = 0
)
(
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        in_valid,
    output logic                                        in_ready,
    input  cmd_t                                        in_cmd,
    input  logic [DIM-1:0][WORD_W-1:0]                  in_vec,
    input  logic [DIM-1:0][PROD_W+$clog2(DIM)-1:0]      in_acc,
    input  logic [DIM-1:0][PROD_W-1:0]                  in_prod,
    output logic                                        out_valid,
    input  logic                                        out_ready,
    output cmd_t                                        out_cmd,
    output logic [DIM-1:0][WORD_W-1:0]                  out_vec,
    output logic [DIM-1:0][PROD_W+$clog2(DIM)-1:0]      out_acc,
    output logic [DIM-1:0][PROD_W-1:0]                  out_prod
);

    localparam int ACC_W = PROD_W + $clog2(DIM);
    localparam logic [WORD_W-1:0] ONE = WORD_W'(1) << FRAC_BITS;

    logic [DIM-1:0][WORD_W-1:0] coeff_reg, coeff_next;
    logic                       valid_reg, valid_next;
    cmd_t                       cmd_reg;
    logic [DIM-1:0][WORD_W-1:0] vec_reg;
    logic [DIM-1:0][ACC_W-1:0]  acc_reg, acc_next;
    logic [DIM-1:0][PROD_W-1:0] prod_reg, prod_next;
    logic                       take;

    assign in_ready = !valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    // Matrix updates land in this column when the request passes this cell, so every
    // transform sees exactly the updates that came before it.
    always_comb
    begin
        coeff_next = coeff_reg;
        if (take)
        begin
            case (in_cmd.op)
                OP_WRITE:
                begin
                    if (int'(in_cmd.col) == K)
                    begin
                        for (int r = 0; r < DIM; r++)
                        begin
                            if (int'(in_cmd.row) == r)
                            begin
                                coeff_next[r] = in_cmd.value;
                            end
                        end
                    end
                end
                OP_IDENT:
                begin
                    for (int r = 0; r < DIM; r++)
                    begin
                        coeff_next[r] = (r == K) ? ONE : '0;
                    end
                end
                OP_CLEAR:
                begin
                    coeff_next = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // The product from the previous cell is folded into the sum here, in parallel
    // with this cell's own multiplies, so no add follows a multiply in the same cycle.
    always_comb
    begin
        logic signed [ACC_W-1:0] p_ext;
        for (int r = 0; r < DIM; r++)
        begin
            p_ext        = $signed(in_prod[r]);
            acc_next[r]  = $signed(in_acc[r]) + p_ext;
            prod_next[r] = mul_q($signed(coeff_reg[r]), $signed(in_vec[K]));
        end
    end

    always_comb
    begin
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            coeff_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            coeff_reg <= coeff_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg  <= in_cmd;
            vec_reg  <= in_vec;
            acc_reg  <= acc_next;
            prod_reg <= prod_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_cmd   = cmd_reg;
    assign out_vec   = vec_reg;
    assign out_acc   = acc_reg;
    assign out_prod  = prod_reg;

    a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        take && in_cmd.op == OP_CLEAR |=> $countones(coeff_reg) == 0)
        else $error("column not cleared");

    a_ident_diag: assert property (@(posedge clk) disable iff (!rst_n)
        take && in_cmd.op == OP_IDENT |=> coeff_reg[K] == ONE
            && $countones(coeff_reg) == 1)
        else $error("identity column wrong");

    a_xform_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        take && in_cmd.op == OP_XFORM |=> $stable(coeff_reg))
        else $error("transform altered the matrix");

endmodule

// File: hw/rtl/mvt_out.sv
// Output stage: final add, arithmetic shift and saturation, then the result register.
// Depends on mvt_pkg.

module mvt_out
    import mvt_pkg::*;
#(
    parameter int DIM       = 4,
    parameter int FRAC_BITS = 16
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  cmd_t                                    in_cmd,
    input  logic [DIM-1:0][PROD_W+$clog2(DIM)-1:0]  in_acc,
    input  logic [DIM-1:0][PROD_W-1:0]              in_prod,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic [NFIELDS-1:0][WORD_W-1:0]          res
);

    localparam int ACC_W = PROD_W + $clog2(DIM);

    logic                             res_valid_reg, res_valid_next;
    logic [NFIELDS-1:0][WORD_W-1:0]   res_reg, res_next;
    logic                             take;
    logic                             is_xform;

    assign in_ready = !res_valid_reg || out_ready;
    assign take     = in_valid && in_ready;
    assign is_xform = in_cmd.op == OP_XFORM;

    for (genvar g = 0; g < NFIELDS; g++)
    begin : g_row
        if (g < DIM)
        begin : g_live
            always_comb
            begin
                logic signed [ACC_W-1:0] p_ext;
                logic signed [ACC_W-1:0] sum;
                logic signed [ACC_W-1:0] sh;
                logic [ACC_W-WORD_W:0]   top;
                p_ext = $signed(in_prod[g]);
                sum   = $signed(in_acc[g]) + p_ext;
                sh    = sum >>> FRAC_BITS;
                top   = sh[ACC_W-1:WORD_W-1];
                // The shifted sum fits only if its upper bits are a pure sign extension.
                if ((&top) || !(|top))
                begin
                    res_next[g] = sh[WORD_W-1:0];
                end
                else
                begin
                    res_next[g] = sh[ACC_W-1] ? WORD_MIN : WORD_MAX;
                end
            end
        end
        else
        begin : g_pad
            assign res_next[g] = '0;
        end
    end

    // Requests that are not transforms leave the chain here without a result.
    always_comb
    begin
        if (take)
        begin
            res_valid_next = is_xform;
        end
        else if (out_ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && is_xform)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = res_valid_reg;
    assign res       = res_reg;

    a_xform_gives: assert property (@(posedge clk) disable iff (!rst_n)
        take && is_xform |=> res_valid_reg)
        else $error("transform produced no result");

    a_other_none: assert property (@(posedge clk) disable iff (!rst_n)
        take && !is_xform |=> !res_valid_reg)
        else $error("result produced for a non-transform request");

    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !out_ready |-> !in_ready)
        else $error("chain drained into a held result");

endmodule

// File: hw/rtl/matrix_vector_transform_unit.sv
// Top level of the matrix-vector transform unit: the chain of column cells and the
// output stage. Depends on mvt_pkg, mvt_cell and mvt_out.

// The unit takes one request per clock unless a held result stalls the chain, and
// returns a result for each transform request in request order. Each request passes
// the chain of DIM cells, one per matrix column, each doing DIM 32x32 multiplies on
// its vector component, followed by one stage for the final add, shift and saturation.
// Matrix writes, identity and clear requests travel down the same chain and update
// each column as they pass, so they take effect in order with transforms. The result
// register closes that last stage: new requests keep entering while a result waits,
// until every stage holds a request.

module matrix_vector_transform_unit
    import mvt_pkg::*;
#(
    parameter int DIM       = 4,
    parameter int FRAC_BITS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          op,
    input  logic [1:0]          row,
    input  logic [1:0]          col,
    input  logic signed [31:0]  value,
    input  logic signed [31:0]  vx,
    input  logic signed [31:0]  vy,
    input  logic signed [31:0]  vz,
    input  logic signed [31:0]  vw,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [31:0]  rx,
    output logic signed [31:0]  ry,
    output logic signed [31:0]  rz,
    output logic signed [31:0]  rw
);

    localparam int ACC_W = PROD_W + $clog2(DIM);

    logic                             c_valid [DIM+1];
    logic                             c_ready [DIM+1];
    cmd_t                             c_cmd   [DIM+1];
    logic [DIM-1:0][WORD_W-1:0]       c_vec   [DIM+1];
    logic [DIM-1:0][ACC_W-1:0]        c_acc   [DIM+1];
    logic [DIM-1:0][PROD_W-1:0]       c_prod  [DIM+1];
    logic [NFIELDS-1:0][WORD_W-1:0]   in_fields;
    logic [NFIELDS-1:0][WORD_W-1:0]   res;

    assign in_fields = {vw, vz, vy, vx};

    assign c_valid[0]     = in_valid;
    assign in_ready       = c_ready[0];
    assign c_cmd[0].op    = op_t'(op);
    assign c_cmd[0].row   = row;
    assign c_cmd[0].col   = col;
    assign c_cmd[0].value = value;
    assign c_acc[0]       = '0;
    assign c_prod[0]      = '0;

    // Components past the four input fields are zero when the matrix is larger.
    for (genvar k = 0; k < DIM; k++)
    begin : g_vec
        if (k < NFIELDS)
        begin : g_in
            assign c_vec[0][k] = in_fields[k];
        end
        else
        begin : g_zero
            assign c_vec[0][k] = '0;
        end
    end

    for (genvar k = 0; k < DIM; k++)
    begin : g_cell
        mvt_cell #(
            .DIM       (DIM),
            .FRAC_BITS (FRAC_BITS),
            .K         (k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (c_valid[k]),
            .in_ready  (c_ready[k]),
            .in_cmd    (c_cmd[k]),
            .in_vec    (c_vec[k]),
            .in_acc    (c_acc[k]),
            .in_prod   (c_prod[k]),
            .out_valid (c_valid[k+1]),
            .out_ready (c_ready[k+1]),
            .out_cmd   (c_cmd[k+1]),
            .out_vec   (c_vec[k+1]),
            .out_acc   (c_acc[k+1]),
            .out_prod  (c_prod[k+1])
        );
    end

    mvt_out #(
        .DIM       (DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (c_valid[DIM]),
        .in_ready  (c_ready[DIM]),
        .in_cmd    (c_cmd[DIM]),
        .in_acc    (c_acc[DIM]),
        .in_prod   (c_prod[DIM]),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res       (res)
    );

    assign rx = res[0];
    assign ry = res[1];
    assign rz = res[2];
    assign rw = res[3];

endmodule
